@@ hw/rtl/aus_pkg.sv @@
package aus_pkg;

    localparam int WIN_DEPTH  = 7;
    localparam int LOOK_DEPTH = 6;

    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_IDR   = 5'd5;
    localparam logic [4:0] NAL_SEI   = 5'd6;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [4:0] NAL_PPS   = 5'd8;

    localparam logic [2:0] SKIP_COUNT   = 3'd3;
    localparam logic [2:0] FILL_EXAMINE = 3'd6;
    localparam logic [2:0] FILL_FULL    = 3'd7;

    typedef struct packed {
        logic [WIN_DEPTH-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      close;
        logic                      fin;
        logic                      no_pic;
    } aus_entry_t;

endpackage

@@ hw/rtl/h264_access_unit_splitter_unit.sv @@
// Channel   Direction  Handshake     Payload
// input     in         push / full   data_byte, stream_end
// result    out        pop / empty   out_byte, unit_last, no_picture, stream_last
//
// One byte is accepted per cycle while full is low; each request leaves the look-ahead window six
// bytes later, with a register stage on the result side.
// The last byte of a stream releases up to seven bytes, one per cycle unless pop stalls them,
// from the entry queue; full rises only when that queue of QUEUE_DEPTH entries fills.
// Reset clears the window fill, picture and skip state and empties the queue.
// Either side may stall without loss; the queue decouples them.
module h264_access_unit_splitter_unit
    import aus_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       stream_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       unit_last,
    output logic       no_picture,
    output logic       stream_last
);

    aus_entry_t entry;
    aus_entry_t head;
    logic       entry_valid;
    logic       head_valid;
    logic       head_pop;
    logic       accept;

    assign accept = push && !full;

    aus_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .stream_end  (stream_end),
        .entry       (entry),
        .entry_valid (entry_valid)
    );

    aus_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (entry_valid),
        .wr_entry   (entry),
        .rd_en      (head_pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    aus_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .head_pop    (head_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .unit_last   (unit_last),
        .no_picture  (no_picture),
        .stream_last (stream_last)
    );

`ifndef SYNTH
    a_stream_last_ends_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && stream_last) |-> unit_last)
        else $error("stream_last without unit_last");

    a_no_picture_ends_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && no_picture) |-> unit_last)
        else $error("no_picture without unit_last");

    a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full while no result is offered");
`endif

endmodule

@@ hw/rtl/aus_front.sv @@
module aus_front
    import aus_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       stream_end,
    output aus_entry_t entry,
    output logic       entry_valid
);

    logic [LOOK_DEPTH-1:0][7:0] win_reg;
    logic [LOOK_DEPTH-1:0][7:0] win_next;
    logic [2:0]                 fill_reg;
    logic [2:0]                 fill_next;
    logic                       pic_reg;
    logic                       pic_next;
    logic [2:0]                 skip_reg;
    logic [2:0]                 skip_next;

    logic [WIN_DEPTH-1:0][7:0]  w;
    logic [LOOK_DEPTH-1:0][7:0] eb;
    logic [2:0]                 fill_new;
    logic                       m3;
    logic                       m4;
    logic [7:0]                 hdr;
    logic [7:0]                 nxt;
    logic [4:0]                 nal_type;
    logic                       first;
    logic                       close;
    logic                       pic_exam;
    logic [2:0]                 skip_exam;
    logic [2:0]                 count;

    // The start position examined is the oldest byte while filling and the
    // second oldest once the window is full.
    always_comb
    begin
        fill_new = fill_reg + 3'd1;
        for (int i = 0; i < LOOK_DEPTH; i++)
        begin
            w[i] = (fill_reg == 3'(i)) ? data_byte : win_reg[i];
        end
        w[WIN_DEPTH-1] = data_byte;
        for (int i = 0; i < LOOK_DEPTH; i++)
        begin
            eb[i] = (fill_new == FILL_FULL) ? w[i+1] : w[i];
        end

        m3 = (eb[0] == 8'h00) && (eb[1] == 8'h00) && (eb[2] == 8'h01);
        m4 = (eb[0] == 8'h00) && (eb[1] == 8'h00) && (eb[2] == 8'h00) && (eb[3] == 8'h01);
        hdr = m3 ? eb[3] : eb[4];
        nxt = m3 ? eb[4] : eb[5];
        nal_type = hdr[4:0];
        first = ((nal_type == NAL_IDR) || (nal_type == NAL_SLICE)) && nxt[7];

        close     = 1'b0;
        pic_exam  = pic_reg;
        skip_exam = skip_reg;
        if (fill_new >= FILL_EXAMINE)
        begin
            if (skip_reg != 3'd0)
            begin
                skip_exam = skip_reg - 3'd1;
            end
            else if (m3 || m4)
            begin
                if (pic_reg && ((nal_type == NAL_SPS) || (nal_type == NAL_PPS) ||
                                (nal_type == NAL_SEI) || first))
                begin
                    close    = 1'b1;
                    pic_exam = 1'b0;
                end
                if (!pic_exam && first)
                begin
                    pic_exam  = 1'b1;
                    skip_exam = SKIP_COUNT;
                end
            end
        end

        if (fill_new == FILL_FULL)
        begin
            count = stream_end ? 3'(WIN_DEPTH) : 3'd1;
        end
        else
        begin
            count = stream_end ? fill_new : 3'd0;
        end

        entry.bytes  = w;
        entry.count  = count;
        entry.close  = close;
        entry.fin    = stream_end;
        entry.no_pic = !pic_exam;
        entry_valid  = accept && (count != 3'd0);

        win_next  = eb;
        fill_next = stream_end ? 3'd0 :
                    ((fill_new == FILL_FULL) ? 3'(LOOK_DEPTH) : fill_new);
        pic_next  = stream_end ? 1'b0 : pic_exam;
        skip_next = stream_end ? 3'd0 : skip_exam;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 3'd0;
            pic_reg  <= 1'b0;
            skip_reg <= 3'd0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            pic_reg  <= pic_next;
            skip_reg <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

endmodule

@@ hw/rtl/aus_queue.sv @@
module aus_queue
    import aus_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  aus_entry_t wr_entry,
    input  logic       rd_en,
    output aus_entry_t head,
    output logic       head_valid,
    output logic       full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aus_entry_t        slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != CW'(0));
    assign full       = (cnt_reg == CW'(DEPTH));

endmodule

@@ hw/rtl/aus_back.sv @@
module aus_back
    import aus_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  aus_entry_t head,
    input  logic       head_valid,
    output logic       head_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       unit_last,
    output logic       no_picture,
    output logic       stream_last
);

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       ul_reg;
    logic       np_reg;
    logic       sl_reg;
    logic       load;
    logic       last;
    logic       fin_last;

    always_comb
    begin
        load     = head_valid && (!valid_reg || pop);
        last     = (idx_reg == (head.count - 3'd1));
        fin_last = head.fin && last;
        head_pop = load && last;
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
        end
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.bytes[idx_reg];
            ul_reg   <= fin_last || ((idx_reg == 3'd0) && head.close);
            np_reg   <= fin_last && head.no_pic;
            sl_reg   <= fin_last;
        end
    end

    assign empty       = !valid_reg;
    assign out_byte    = byte_reg;
    assign unit_last   = ul_reg;
    assign no_picture  = np_reg;
    assign stream_last = sl_reg;

endmodule

@@ verif/h264_access_unit_splitter_unit_tb.sv @@
module h264_access_unit_splitter_unit_tb;
    import aus_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       fin;
    } byte_req_t;

    typedef struct packed {
        logic [7:0] value;
        logic       unit_end;
        logic       no_pic;
        logic       fin;
    } split_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] data_byte = 8'h00;
    logic       stream_end = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_byte;
    logic       unit_last;
    logic       no_picture;
    logic       stream_last;

    byte_req_t   pending_bytes[$];
    split_byte_t expected_bytes[$];

    logic [7:0] win [WIN_DEPTH];
    logic [2:0] win_fill;
    logic       pic_open;
    logic [2:0] skip_cnt;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic recv_hold = 1'b0;
    int errors = 0;
    int bytes_sent = 0;
    int streams_sent = 0;
    int bytes_checked = 0;
    int units_closed = 0;
    int full_cycles = 0;

    h264_access_unit_splitter_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .stream_end  (stream_end),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .unit_last   (unit_last),
        .no_picture  (no_picture),
        .stream_last (stream_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic void clear_splitter();
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            win[i] = 8'h00;
        end
        win_fill = 3'd0;
        pic_open = 1'b0;
        skip_cnt = 3'd0;
    endfunction

    // Looks for a start code at window offset o and returns 1 when it closes a unit.
    function automatic logic scan_start(int o);
        logic [7:0] hdr;
        logic [7:0] nxt;
        logic [4:0] nal;
        logic       first;
        logic       closes;
        closes = 1'b0;
        if (skip_cnt != 3'd0)
        begin
            skip_cnt = skip_cnt - 3'd1;
            return 1'b0;
        end
        if (win[o] == 8'h00 && win[o+1] == 8'h00 && win[o+2] == 8'h01)
        begin
            hdr = win[o+3];
            nxt = win[o+4];
        end
        else if (win[o] == 8'h00 && win[o+1] == 8'h00 && win[o+2] == 8'h00
                 && win[o+3] == 8'h01)
        begin
            hdr = win[o+4];
            nxt = win[o+5];
        end
        else
        begin
            return 1'b0;
        end
        nal = hdr[4:0];
        first = (nal == NAL_IDR || nal == NAL_SLICE) && nxt[7];
        if (pic_open && (nal == NAL_SPS || nal == NAL_PPS || nal == NAL_SEI || first))
        begin
            closes = 1'b1;
            pic_open = 1'b0;
        end
        if (!pic_open && first)
        begin
            pic_open = 1'b1;
            skip_cnt = SKIP_COUNT;
        end
        return closes;
    endfunction

    task automatic predict_byte(input logic [7:0] value, input logic fin);
        logic closes;
        logic last;
        win[win_fill] = value;
        win_fill = win_fill + 3'd1;
        if (win_fill == FILL_EXAMINE)
        begin
            void'(scan_start(0));
        end
        else if (win_fill == FILL_FULL)
        begin
            closes = scan_start(1);
            expected_bytes.push_back('{win[0], closes, 1'b0, 1'b0});
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win[i] = win[i+1];
            end
            win[WIN_DEPTH-1] = 8'h00;
            win_fill = FILL_EXAMINE;
        end
        if (fin)
        begin
            for (int i = 0; i < win_fill; i++)
            begin
                last = (i + 1 == win_fill);
                expected_bytes.push_back('{win[i], last, last && !pic_open, last});
            end
            clear_splitter();
            streams_sent++;
        end
    endtask

    task automatic queue_byte(input logic [7:0] value);
        pending_bytes.push_back('{value, 1'b0});
    endtask

    task automatic close_stream();
        pending_bytes[pending_bytes.size()-1].fin = 1'b1;
    endtask

    task automatic queue_directed();
        logic [7:0] seq [22];
        seq = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h88,
                8'h00, 8'h00, 8'h01, 8'h67, 8'h42,
                8'h00, 8'h00, 8'h01, 8'h41, 8'h9A,
                8'h00, 8'h00, 8'h01, 8'h25, 8'h9A, 8'hFF};
        foreach (seq[i])
        begin
            queue_byte(seq[i]);
        end
        close_stream();
    endtask

    // Mostly well-formed NAL sequences with random content, some noise and broken start codes.
    task automatic add_random_stream();
        int kind;
        int nals;
        int sel;
        logic [4:0] nal;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(12, 1))
            begin
                queue_byte(roll(40) ? 8'h00 : 8'($urandom_range(255)));
            end
        end
        else
        begin
            nals = $urandom_range(6, 1);
            repeat (nals)
            begin
                if (roll(10))
                begin
                    queue_byte(8'h00);
                    queue_byte(roll(50) ? 8'h00 : 8'h01);
                    queue_byte(8'($urandom_range(255)));
                end
                else
                begin
                    if (roll(40))
                    begin
                        queue_byte(8'h00);
                    end
                    queue_byte(8'h00);
                    queue_byte(8'h00);
                    queue_byte(8'h01);
                end
                sel = $urandom_range(9);
                if (sel < 3)
                begin
                    nal = NAL_SLICE;
                end
                else if (sel < 5)
                begin
                    nal = NAL_IDR;
                end
                else if (sel == 5)
                begin
                    nal = NAL_SPS;
                end
                else if (sel == 6)
                begin
                    nal = NAL_PPS;
                end
                else if (sel == 7)
                begin
                    nal = NAL_SEI;
                end
                else
                begin
                    nal = 5'($urandom_range(31));
                end
                queue_byte({3'($urandom_range(7)), nal});
                queue_byte({roll(75), 7'($urandom_range(127))});
                repeat ($urandom_range(6))
                begin
                    queue_byte(roll(20) ? 8'h00 : 8'($urandom_range(255)));
                end
            end
        end
        close_stream();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        byte_req_t nxt_req;
        if (!rst_n)
        begin
            push <= 1'b0;
            data_byte <= 8'h00;
            stream_end <= 1'b0;
        end
        else
        begin
            if (push && full)
            begin
                full_cycles++;
            end
            if (push && !full)
            begin
                predict_byte(data_byte, stream_end);
                bytes_sent++;
            end
            if (!(push && full))
            begin
                if (pending_bytes.size() > 0 && !roll(send_idle_pct))
                begin
                    nxt_req = pending_bytes.pop_front();
                    push <= 1'b1;
                    data_byte <= nxt_req.value;
                    stream_end <= nxt_req.fin;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        split_byte_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("unexpected out_byte", out_byte, 0);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (want.unit_end)
                    begin
                        units_closed++;
                    end
                    if (out_byte !== want.value)
                    begin
                        report_mismatch("out_byte", out_byte, want.value);
                    end
                    if (unit_last !== want.unit_end)
                    begin
                        report_mismatch("unit_last", unit_last, want.unit_end);
                    end
                    if (no_picture !== want.no_pic)
                    begin
                        report_mismatch("no_picture", no_picture, want.no_pic);
                    end
                    if (stream_last !== want.fin)
                    begin
                        report_mismatch("stream_last", stream_last, want.fin);
                    end
                end
            end
            pop <= !recv_hold && !roll(recv_idle_pct);
        end
    end

    initial
    begin
        wait (bytes_sent >= 90);
        @(negedge clk);
        recv_hold = 1'b1;
        repeat (300) @(negedge clk);
        recv_hold = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic wait_drained();
        @(negedge clk);
        while (pending_bytes.size() > 0 || push)
        begin
            @(negedge clk);
        end
        while (expected_bytes.size() > 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int n_bytes);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        while (pending_bytes.size() < n_bytes)
        begin
            add_random_stream();
        end
        wait_drained();
    endtask

    initial
    begin
        clear_splitter();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        pending_bytes.push_back('{8'h00, 1'b1});
        queue_directed();
        wait_drained();

        run_phase(6, 79, 170);
        run_phase(79, 6, 170);
        run_phase(0, 0, 170);

        repeat (20) @(negedge clk);
        while (expected_bytes.size() > 0)
        begin
            report_mismatch("missing result, out_byte", 0, expected_bytes[0].value);
            void'(expected_bytes.pop_front());
        end
        $display("Sent %0d bytes in %0d streams; checked %0d bytes and %0d unit ends.",
                 bytes_sent, streams_sent, bytes_checked, units_closed);
        $display("Input was held off by full for %0d cycles.", full_cycles);
        if (errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/aus_pkg.sv
hw/rtl/aus_front.sv
hw/rtl/aus_queue.sv
hw/rtl/aus_back.sv
hw/rtl/h264_access_unit_splitter_unit.sv
verif/h264_access_unit_splitter_unit_tb.sv
